// ----- rtl/med33_pkg.sv -----
// shared types, register indexes and sorting helpers for the 3x3 median filter
package med33_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_W = CFG_W + 1;
    localparam int CFG_RST_DIM = 1024;

    typedef logic [PIX_W-1:0] pix_t;

    localparam pix_t PIX_MAX = {PIX_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // one window column, sorted low to high
    typedef struct packed {
        pix_t lo;
        pix_t md;
        pix_t hi;
    } col_t;

    // line buffer write bundle
    typedef struct packed {
        logic en;
        pix_t a;
        pix_t b;
    } lb_wr_t;

    function automatic pix_t pmin(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t pmax(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return pmin(pmin(a, b), c);
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return pmax(pmax(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return pmax(pmin(a, b), pmin(pmax(a, b), c));
    endfunction

    function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t lo1;
        pix_t hi1;
        pix_t t;
        col_t r;
        lo1  = pmin(a, b);
        hi1  = pmax(a, b);
        r.lo = pmin(lo1, c);
        t    = pmax(lo1, c);
        r.md = pmin(t, hi1);
        r.hi = pmax(t, hi1);
        return r;
    endfunction

endpackage

// ----- rtl/med33_linebuf.sv -----
// two row line buffers with registered read and write-to-read bypass
module med33_linebuf #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    input  med33_pkg::lb_wr_t     wr,
    input  logic [AW-1:0]         wr_addr,
    output med33_pkg::pix_t       rd_a,
    output med33_pkg::pix_t       rd_b
);

    med33_pkg::pix_t mem_a [DEPTH];
    med33_pkg::pix_t mem_b [DEPTH];

    med33_pkg::pix_t rd_a_reg;
    med33_pkg::pix_t rd_b_reg;
    med33_pkg::pix_t fwd_a_reg;
    med33_pkg::pix_t fwd_b_reg;
    logic            fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_a[wr_addr] <= wr.a;
            mem_b[wr_addr] <= wr.b;
        end
        if (rd_en)
        begin
            rd_a_reg  <= mem_a[rd_addr];
            rd_b_reg  <= mem_b[rd_addr];
            fwd_a_reg <= wr.a;
            fwd_b_reg <= wr.b;
        end
    end

    // same-address write in the read cycle wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr.en && (wr_addr == rd_addr);
        end
    end

    assign rd_a = fwd_reg ? fwd_a_reg : rd_a_reg;
    assign rd_b = fwd_reg ? fwd_b_reg : rd_b_reg;

endmodule

// ----- rtl/median_3x3_replicate_border.sv -----
// top level of the streaming 3x3 median filter with replicated border
//
//  channel  direction  handshake                 payload
//  cfg      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//  in       in         in_valid / in_stall       cmd, pixel_in
//  out      out        out_valid / out_stall     median_out, min_so_far, max_so_far, frame_last
//
// one input beat per clock unless stalled; accept -> window stage register -> result register
// median of pixel (r,c) leaves with the beat of input (r+1,c+1), or (r+2,0) for the
// right edge, so image_width+1 flush beats drain a frame
// the rate is set by the line buffers: one read and one write per beat on each
// rst_n clears counters, valids, running min/max; the line buffers are not cleared
// out_stall holds the result register and the stage behind it; a full stage raises in_stall
module median_3x3_replicate_border #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [med33_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [med33_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  med33_pkg::pix_t                     pixel_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output med33_pkg::pix_t                     median_out,
    output med33_pkg::pix_t                     min_so_far,
    output med33_pkg::pix_t                     max_so_far,
    output logic                                frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = med33_pkg::ROW_W;
    localparam int CW = med33_pkg::CFG_W;
    localparam int RST_W = (MAX_WIDTH < med33_pkg::CFG_RST_DIM) ?
                           MAX_WIDTH : med33_pkg::CFG_RST_DIM;
    localparam logic [AW-1:0] RST_W_M1 = AW'(RST_W - 1);
    localparam logic [AW-1:0] MAX_W_M1 = AW'(MAX_WIDTH - 1);

    // item info carried from accept to the window stage
    typedef struct packed {
        logic [AW-1:0]   ci;
        logic            col_zero;
        logic            top_same;
        logic            in_frame;
        med33_pkg::pix_t pix;
        logic            emit;
        logic            last;
        logic            we;
    } s1_t;

    // configuration
    logic [AW-1:0] w_m1_reg;
    logic [CW-1:0] h_reg;
    logic [AW-1:0] w_m1_cfg;
    logic [CW-1:0] h_cfg;
    logic          cfg_fire;
    logic          restart;

    // input side counters
    logic [AW-1:0] in_col_reg;
    logic [AW-1:0] in_col_next;
    logic [RW-1:0] in_row_reg;
    logic [RW-1:0] in_row_next;
    logic [RW-1:0] h_ext;

    logic          in_frame_a;
    logic          col_zero_a;
    logic          emit_a;
    logic          last_a;
    logic          we_a;
    logic          top_same_a;
    logic          in_fire;
    logic          load_a;

    // window stage
    logic            s1_valid_reg;
    s1_t             s1_reg;
    logic            s1_adv;
    logic            s1_fire;
    med33_pkg::pix_t lb_a;
    med33_pkg::pix_t lb_b;
    med33_pkg::pix_t top;
    med33_pkg::pix_t mid;
    med33_pkg::pix_t bot;
    med33_pkg::col_t new_col;
    med33_pkg::col_t win_reg [3];
    med33_pkg::col_t e0;
    med33_pkg::col_t e1;
    med33_pkg::col_t e2;
    med33_pkg::pix_t med;
    med33_pkg::pix_t min_new;
    med33_pkg::pix_t max_new;
    med33_pkg::lb_wr_t lb_wr;

    med33_pkg::pix_t run_min_reg;
    med33_pkg::pix_t run_max_reg;

    // result register
    logic            out_valid_reg;
    med33_pkg::pix_t median_reg;
    med33_pkg::pix_t min_reg;
    med33_pkg::pix_t max_reg;
    logic            last_reg;

    //--------------------------------------------------------------------
    // configuration port, always ready; width clamps to 1..MAX_WIDTH, height to >= 1
    //--------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            w_m1_cfg = '0;
        end
        else if (32'(cfg_data) > 32'(MAX_WIDTH))
        begin
            w_m1_cfg = MAX_W_M1;
        end
        else
        begin
            w_m1_cfg = AW'(32'(cfg_data) - 32'd1);
        end
        h_cfg = (cfg_data == '0) ? CW'(1) : cfg_data;
    end

    always_comb
    begin
        case (cfg_index)
            med33_pkg::REG_IMAGE_WIDTH:  restart = cfg_fire;
            med33_pkg::REG_IMAGE_HEIGHT: restart = cfg_fire;
            default:                     restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg <= RST_W_M1;
            h_reg    <= CW'(med33_pkg::CFG_RST_DIM);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                med33_pkg::REG_IMAGE_WIDTH:  w_m1_reg <= w_m1_cfg;
                med33_pkg::REG_IMAGE_HEIGHT: h_reg    <= h_cfg;
                default:                     ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // accept: decide what the beat does from the input position
    //--------------------------------------------------------------------
    assign h_ext      = {1'b0, h_reg};
    assign in_frame_a = in_row_reg < h_ext;
    assign col_zero_a = (in_col_reg == '0);
    // row start emits the right edge of two rows back, else the pixel up-left
    assign emit_a     = col_zero_a ? (in_row_reg >= RW'(2)) : (in_row_reg != '0);
    // right edge of the last row closes the frame
    assign last_a     = col_zero_a && (in_row_reg == h_ext + RW'(1));
    assign we_a       = in_row_reg <= h_ext;
    assign top_same_a = in_row_reg <= RW'(1);

    // stage moves when the result register is free or being emptied
    assign s1_adv   = !(out_valid_reg && out_stall);
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;
    // a flush beat inside the frame is dropped without effect
    assign load_a   = in_fire && !(cmd && in_frame_a);

    always_comb
    begin
        if (last_a)
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
        else if (in_col_reg == w_m1_reg)
        begin
            in_col_next = '0;
            in_row_next = in_row_reg + RW'(1);
        end
        else
        begin
            in_col_next = in_col_reg + AW'(1);
            in_row_next = in_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                in_col_reg <= '0;
                in_row_reg <= '0;
            end
            else if (load_a)
            begin
                in_col_reg <= in_col_next;
                in_row_reg <= in_row_next;
            end
            if (load_a)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            s1_reg.ci       <= in_col_reg;
            s1_reg.col_zero <= col_zero_a;
            s1_reg.top_same <= top_same_a;
            s1_reg.in_frame <= in_frame_a;
            s1_reg.pix      <= pixel_in;
            s1_reg.emit     <= emit_a;
            s1_reg.last     <= last_a;
            s1_reg.we       <= we_a;
        end
    end

    //--------------------------------------------------------------------
    // line buffers: a holds the row above b, b the row above the current one
    //--------------------------------------------------------------------
    assign lb_wr.en = s1_fire && s1_reg.we;
    assign lb_wr.a  = mid;
    assign lb_wr.b  = bot;

    med33_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_linebuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (load_a),
        .rd_addr (in_col_reg),
        .wr      (lb_wr),
        .wr_addr (s1_reg.ci),
        .rd_a    (lb_a),
        .rd_b    (lb_b)
    );

    //--------------------------------------------------------------------
    // window stage: columns are kept sorted, so the median is a short tree
    //--------------------------------------------------------------------
    // top border repeats the middle row, bottom border (flush rows) repeats it too
    assign mid     = lb_b;
    assign top     = s1_reg.top_same ? mid : lb_a;
    assign bot     = s1_reg.in_frame ? s1_reg.pix : mid;
    assign new_col = med33_pkg::sort3(top, mid, bot);

    always_comb
    begin
        e0 = win_reg[1];
        e1 = win_reg[2];
        // row start closes the previous row by repeating its right column
        e2 = s1_reg.col_zero ? win_reg[2] : new_col;
    end

    assign med = med33_pkg::med3(med33_pkg::max3(e0.lo, e1.lo, e2.lo),
                                 med33_pkg::med3(e0.md, e1.md, e2.md),
                                 med33_pkg::min3(e0.hi, e1.hi, e2.hi));

    assign min_new = med33_pkg::pmin(run_min_reg, med);
    assign max_new = med33_pkg::pmax(run_max_reg, med);

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_reg.we)
        begin
            if (s1_reg.col_zero)
            begin
                // left border: all three columns take the first column
                win_reg[0] <= new_col;
                win_reg[1] <= new_col;
                win_reg[2] <= new_col;
            end
            else
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= new_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg   <= med33_pkg::PIX_MAX;
            run_max_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart || (s1_fire && s1_reg.emit && s1_reg.last))
            begin
                run_min_reg <= med33_pkg::PIX_MAX;
                run_max_reg <= '0;
            end
            else if (s1_fire && s1_reg.emit)
            begin
                run_min_reg <= min_new;
                run_max_reg <= max_new;
            end
            if (s1_fire && s1_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_reg.emit)
        begin
            median_reg <= med;
            min_reg    <= min_new;
            max_reg    <= max_new;
            last_reg   <= s1_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign median_out = median_reg;
    assign min_so_far = min_reg;
    assign max_so_far = max_reg;
    assign frame_last = last_reg;

endmodule

// ----- rtl/med33_checker.sv -----
// port-level checks for the 3x3 median filter, bound to the top level
module med33_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cfg_valid,
    input logic            cfg_ready,
    input logic            in_valid,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input med33_pkg::pix_t median_out,
    input med33_pkg::pix_t min_so_far,
    input med33_pkg::pix_t max_so_far,
    input logic            frame_last
);

    logic            have_prev_reg;
    med33_pkg::pix_t prev_min_reg;
    med33_pkg::pix_t prev_max_reg;
    logic            out_fire;

    assign out_fire = out_valid && !out_stall;

    // set once a beat of the current frame has passed, cleared at frame end or reconfiguration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            have_prev_reg <= !frame_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            prev_min_reg <= min_so_far;
            prev_max_reg <= max_so_far;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median_out) &&
            $stable(min_so_far) && $stable(max_so_far) && $stable(frame_last))
        else $error("stalled result beat changed");

    // running bounds enclose the median and only widen within a frame
    a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && have_prev_reg |-> min_so_far <= median_out &&
            median_out <= max_so_far && min_so_far <= prev_min_reg &&
            max_so_far >= prev_max_reg)
        else $error("running min or max went the wrong way");

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty result register");

endmodule

bind median_3x3_replicate_border med33_checker u_med33_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .median_out (median_out),
    .min_so_far (min_so_far),
    .max_so_far (max_so_far),
    .frame_last (frame_last)
);
